// ===== hw/rtl/wlan_client_station_tracker_macros.svh =====
// ----------------------------------------------------------------------------
// wlan_client_station_tracker_macros.svh
// Assertion macros used by the station tracker checker.
// ----------------------------------------------------------------------------
`ifndef WLAN_CLIENT_STATION_TRACKER_MACROS_SVH
`define WLAN_CLIENT_STATION_TRACKER_MACROS_SVH

// Concurrent check, sampled on clk, masked while arst_n is low.
`define WCST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Concurrent check, sampled on clk, also live during reset.
`define WCST_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/wcst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcst_pkg
// Types, constants and controller encodings of the client station tracker.
// ----------------------------------------------------------------------------
package wcst_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

	localparam int ADDR_W      = 48;
	localparam int FC_W        = 16;
	localparam int OUT_COUNT_W = 7;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_ADDRESS  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_TRACKED    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PURGE_INTERVAL = 2'd2;

	localparam logic [ADDR_W-1:0] LOCAL_ADDRESS_RST  = '0;
	localparam logic [5:0]        MAX_TRACKED_RST    = 6'd32;
	localparam logic [15:0]       PURGE_INTERVAL_RST = 16'd60;

	// Opcodes.
	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// Frame control fields.
	localparam logic [1:0] FC_TYPE_DATA = 2'd2;
	localparam int FC_TYPE_LSB  = 2;
	localparam int FC_QOS_BIT   = 7;
	localparam int FC_TO_DS     = 8;
	localparam int FC_FROM_DS   = 9;

	typedef struct packed {
		logic              opcode;
		logic [FC_W-1:0]   frame_control;
		logic [ADDR_W-1:0] receiver_address;
		logic [ADDR_W-1:0] transmitter_address;
	} in_item_t;

	typedef struct packed {
		logic                   new_client;
		logic [ADDR_W-1:0]      client_address;
		logic [ADDR_W-1:0]      access_point_address;
		logic                   qos_frame;
		logic                   flushed;
		logic [OUT_COUNT_W-1:0] client_count;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic start;
		logic scan_en;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic in_tick;
		logic scan_done;
		logic out_free;
	} dp_status_t;

endpackage

// ===== hw/rtl/wcst_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcst_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wcst_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/wcst_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcst_ctrl
// Sequencer: accept a word, run the table scan for frames, commit the result.
// ----------------------------------------------------------------------------
module wcst_ctrl
	import wcst_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = status.in_tick ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.scan_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		cmd.start   = 1'b0;
		cmd.scan_en = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				cmd.start = in_valid;
			end
			ST_SCAN: begin
				cmd.scan_en = 1'b1;
			end
			ST_FINISH: begin
				cmd.commit = status.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// ===== hw/rtl/wcst_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcst_dp
// Datapath: config registers, client table, scan compare, counters, output.
// ----------------------------------------------------------------------------
module wcst_dp
	import wcst_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  in_item_t               in_data,
	output out_item_t              out_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]      cfg_data,
	input  ctrl_cmd_t              cmd,
	output dp_status_t             status
);

	logic [ADDR_W-1:0]  local_address_q;
	logic [5:0]         max_tracked_q;
	logic [15:0]        purge_interval_q;

	in_item_t           item_q;
	logic [COUNT_W-1:0] count_q;
	logic [15:0]        elapsed_q;
	logic [COUNT_W-1:0] scan_idx_q;
	logic               rd_vld_q;
	logic               hit_q;
	logic               out_valid_q;
	out_item_t          out_data_q;

	logic [ADDR_W-1:0]  rd_data;
	logic               issue;
	logic               eligible;
	logic               record;
	logic               flush;
	logic [COUNT_W-1:0] new_count;
	logic [COUNT_W-1:0] final_count;

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_address_q  <= LOCAL_ADDRESS_RST;
			max_tracked_q    <= MAX_TRACKED_RST;
			purge_interval_q <= PURGE_INTERVAL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOCAL_ADDRESS:  local_address_q  <= cfg_data;
				REG_MAX_TRACKED:    max_tracked_q    <= cfg_data[5:0];
				REG_PURGE_INTERVAL: purge_interval_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			item_q <= in_data;
		end
	end

	// Sweep the filled part of the table, one read per cycle.
	assign issue = cmd.scan_en && (scan_idx_q != count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			rd_vld_q   <= 1'b0;
			hit_q      <= 1'b0;
		end else if (cmd.start) begin
			scan_idx_q <= '0;
			rd_vld_q   <= 1'b0;
			hit_q      <= 1'b0;
		end else begin
			rd_vld_q <= issue;
			if (issue) begin
				scan_idx_q <= scan_idx_q + COUNT_W'(1);
			end
			if (rd_vld_q && (rd_data == item_q.transmitter_address)) begin
				hit_q <= 1'b1;
			end
		end
	end

	assign eligible = (item_q.frame_control[FC_TYPE_LSB +: 2] == FC_TYPE_DATA)
		&& item_q.frame_control[FC_TO_DS]
		&& !item_q.frame_control[FC_FROM_DS]
		&& (item_q.receiver_address != '0)
		&& (item_q.receiver_address != '1)
		&& (item_q.transmitter_address != local_address_q);

	assign record = eligible && !hit_q && (count_q < COUNT_W'(TABLE_DEPTH));
	assign new_count = count_q + COUNT_W'(record);
	assign flush = (16'(new_count) > 16'(max_tracked_q)) || (elapsed_q >= purge_interval_q);
	assign final_count = flush ? '0 : new_count;

	wcst_ram #(
		.WIDTH(ADDR_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (cmd.commit && (item_q.opcode == OP_FRAME) && record),
		.waddr(count_q[IDX_W-1:0]),
		.wdata(item_q.transmitter_address),
		.re   (issue),
		.raddr(scan_idx_q[IDX_W-1:0]),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			elapsed_q <= '0;
		end else if (cmd.commit) begin
			if (item_q.opcode == OP_TICK) begin
				if (elapsed_q != '1) begin
					elapsed_q <= elapsed_q + 16'd1;
				end
			end else begin
				count_q <= final_count;
				if (flush) begin
					elapsed_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (item_q.opcode == OP_TICK) begin
				out_data_q.new_client           <= 1'b0;
				out_data_q.client_address       <= '0;
				out_data_q.access_point_address <= '0;
				out_data_q.qos_frame            <= 1'b0;
				out_data_q.flushed              <= 1'b0;
				out_data_q.client_count         <= OUT_COUNT_W'(count_q);
			end else begin
				out_data_q.new_client           <= record && !flush;
				out_data_q.client_address       <= (record && !flush) ?
					item_q.transmitter_address : '0;
				out_data_q.access_point_address <= (record && !flush) ?
					item_q.receiver_address : '0;
				out_data_q.qos_frame            <= item_q.frame_control[FC_QOS_BIT];
				out_data_q.flushed              <= flush;
				out_data_q.client_count         <= OUT_COUNT_W'(final_count);
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign out_data         = out_data_q;
	assign status.in_tick   = (in_data.opcode == OP_TICK);
	assign status.scan_done = (scan_idx_q == count_q) && !rd_vld_q;
	assign status.out_free  = !out_valid_q || !out_stall;

endmodule

// ===== hw/rtl/wlan_client_station_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlan_client_station_tracker
// Learns client stations from to-DS data frame headers and reports new ones.
// ----------------------------------------------------------------------------
// Each input word is either a one-second tick or the frame control, address 1
// and address 2 of a received 802.11 header, and produces exactly one output
// word. A frame qualifies when it is a data frame with to-DS set and from-DS
// clear, address 1 is neither zero nor broadcast, and address 2 differs from
// local_address; an unknown address 2 is appended to the client table. After
// every frame the table is flushed when the count exceeds max_tracked or the
// elapsed seconds reach purge_interval, and a client recorded and not flushed
// away is reported with new_client set. The time that a frame occupies the
// block between accepts grows with the number of clients currently in the
// 64-entry table, as the table scan reads one entry per cycle through the
// single read port of the table RAM; a tick skips the scan. The result sits
// in an output register, so the next word is accepted while it waits; a
// word finishes only once that register is free. Configuration writes are
// taken in any cycle but should only be issued while the block is idle. No
// clearing pass is needed after reset: entries beyond the fill count are
// never read.
// ----------------------------------------------------------------------------
module wlan_client_station_tracker
	import wcst_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_data,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]      cfg_data
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Sequencer: accept, scan, commit.
	wcst_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status  (status),
		.cmd     (cmd)
	);

	// Table, counters, config registers and output register.
	wcst_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.out_data (out_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.status   (status)
	);

endmodule

// ===== hw/rtl/wcst_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcst_checker
// Port-level checks on the result channel of the station tracker.
// ----------------------------------------------------------------------------
`include "wlan_client_station_tracker_macros.svh"

module wcst_checker
	import wcst_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	`WCST_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result word changed while stalled")
	`WCST_ASSERT(a_new_not_flushed, out_valid |-> !(out_data.new_client && out_data.flushed), "new client reported on a flushed word")
	`WCST_ASSERT(a_idle_addr_zero, out_valid && !out_data.new_client |-> (out_data.client_address == '0) && (out_data.access_point_address == '0), "addresses set without a new client")
	`WCST_ASSERT(a_flush_empties, out_valid && out_data.flushed |-> out_data.client_count == '0, "flushed word shows a nonzero count")

endmodule

bind wlan_client_station_tracker wcst_checker u_wcst_checker (.*);

// ===== dv/client_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// client_table_checker
// Watches the station tracker's channels, predicts every result word and
// compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module client_table_checker
	import wcst_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  in_item_t               in_data,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  out_item_t              out_data,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]      cfg_data,
	output int                     mismatches,
	output int                     pending,
	output int                     reports_seen,
	output int                     flushes_seen
);

	out_item_t         pending_reports[$];

	logic [ADDR_W-1:0] clients [TABLE_DEPTH];
	int                fill;
	int                announced;
	logic [15:0]       seconds;
	logic [ADDR_W-1:0] own_addr;
	logic [5:0]        cap;
	logic [15:0]       period;

	initial begin
		mismatches   = 0;
		pending      = 0;
		reports_seen = 0;
		flushes_seen = 0;
	end

	function automatic void check_field(string name, logic [ADDR_W-1:0] want,
			logic [ADDR_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Apply one word to the tracked table and return the result it must give.
	function automatic out_item_t learn_station(in_item_t w);
		out_item_t res;
		logic      seen;
		logic      recorded;
		logic      wanted;
		int        i;
		res      = '0;
		recorded = 1'b0;
		if (w.opcode == OP_TICK) begin
			if (seconds != 16'hFFFF) seconds = seconds + 16'd1;
		end else begin
			res.qos_frame = w.frame_control[FC_QOS_BIT];
			seen = 1'b0;
			for (i = 0; i < fill; i++)
				if (clients[i] == w.transmitter_address) seen = 1'b1;
			wanted = w.frame_control[FC_TYPE_LSB +: 2] == FC_TYPE_DATA
				&& w.frame_control[FC_TO_DS] && !w.frame_control[FC_FROM_DS]
				&& w.receiver_address != '0 && w.receiver_address != '1
				&& w.transmitter_address != own_addr;
			if (wanted && !seen && fill < TABLE_DEPTH) begin
				clients[fill] = w.transmitter_address;
				fill++;
				recorded = 1'b1;
			end
			if (fill > int'(cap) || seconds >= period) begin
				fill        = 0;
				announced   = 0;
				seconds     = '0;
				res.flushed = 1'b1;
				flushes_seen++;
			end
			if (recorded && fill > announced) begin
				announced                = fill;
				res.new_client           = 1'b1;
				res.client_address       = w.transmitter_address;
				res.access_point_address = w.receiver_address;
				reports_seen++;
			end
		end
		res.client_count = 7'(fill);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			pending_reports.delete();
			fill      = 0;
			announced = 0;
			seconds   = '0;
			own_addr  = LOCAL_ADDRESS_RST;
			cap       = MAX_TRACKED_RST;
			period    = PURGE_INTERVAL_RST;
			pending  <= 0;
		end else begin
			// Compare the delivered word before queueing this edge's prediction.
			if (out_valid && !out_stall) begin
				if (pending_reports.size() == 0) begin
					$error("result word with nothing expected: 0x%0h", out_data);
					mismatches++;
				end else begin
					want = pending_reports.pop_front();
					check_field("new_client", ADDR_W'(want.new_client),
						ADDR_W'(out_data.new_client));
					check_field("client_address", want.client_address,
						out_data.client_address);
					check_field("access_point_address", want.access_point_address,
						out_data.access_point_address);
					check_field("qos_frame", ADDR_W'(want.qos_frame),
						ADDR_W'(out_data.qos_frame));
					check_field("flushed", ADDR_W'(want.flushed),
						ADDR_W'(out_data.flushed));
					check_field("client_count", ADDR_W'(want.client_count),
						ADDR_W'(out_data.client_count));
				end
			end
			if (in_valid && !in_stall)
				pending_reports.push_back(learn_station(in_data));
			if (cfg_we) begin
				case (cfg_index)
					REG_LOCAL_ADDRESS:  own_addr = cfg_data;
					REG_MAX_TRACKED:    cap      = cfg_data[5:0];
					REG_PURGE_INTERVAL: period   = cfg_data[15:0];
					default: ;
				endcase
			end
			pending <= pending_reports.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives frame headers and ticks into the client station tracker.
// ----------------------------------------------------------------------------
// A short directed sequence walks through every rejection reason, known and
// new clients, flushes by count and by time and the zero flush period. Then
// several register settings follow, each with a burst of mostly well-formed
// to-DS data frames drawn from a small station pool so that clients repeat,
// mixed with ticks and malformed headers. The checker beside the block
// predicts and compares every result word; this module only makes stimulus,
// random idling on both sides and the final verdict.
// ----------------------------------------------------------------------------
module testbench;
	import wcst_pkg::*;

	localparam int PHASES        = 8;
	localparam int WORDS_A_PHASE = 190;
	localparam int POOL_SIZE     = 80;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_LIMIT   = 20000;

	// Frame control words: type/subtype in the low byte, DS bits above.
	localparam logic [15:0] FC_QOS_DATA_TO_DS = 16'h0188;
	localparam logic [15:0] FC_DATA_TO_DS     = 16'h0108;
	localparam logic [15:0] FC_DATA_BOTH_DS   = 16'h0308;
	localparam logic [15:0] FC_DATA_NO_DS     = 16'h0008;
	localparam logic [15:0] FC_MGMT_TO_DS     = 16'h0100;

	localparam logic [ADDR_W-1:0] AP_ADDR = 48'h0200_0000_0001;
	localparam logic [ADDR_W-1:0] STA_A   = 48'h0a1b_2c3d_4e5f;
	localparam logic [ADDR_W-1:0] STA_B   = 48'h7c00_0000_0b0b;
	localparam logic [ADDR_W-1:0] STA_C   = 48'h0000_00c0_ffee;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_stall;
	in_item_t               in_data   = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	out_item_t              out_data;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_LOCAL_ADDRESS;
	logic [ADDR_W-1:0]      cfg_data  = '0;

	int mismatches;
	int pending;
	int reports_seen;
	int flushes_seen;

	// Idling and hold-off controls, owned by the stimulus process.
	logic in_gaps   = 1'b1;
	logic out_gaps  = 1'b1;
	logic hold_req  = 1'b0;
	logic hold_seen = 1'b0;
	int   hold_left = 0;

	logic [ADDR_W-1:0] stations [POOL_SIZE];
	logic [ADDR_W-1:0] own_address = '0;
	int                words_sent  = 0;
	int                settings_run = 0;

	always #10 clk = ~clk;

	wlan_client_station_tracker u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	client_table_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pending      (pending),
		.reports_seen (reports_seen),
		.flushes_seen (flushes_seen)
	);

	// Receiver: a toggle of hold_req starts a long hold-off; otherwise stall
	// at random while out_gaps is set.
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= out_gaps && ($urandom_range(99) < 16);
		end
	end

	function automatic logic [ADDR_W-1:0] random_mac();
		return {16'($urandom), $urandom};
	endfunction

	function automatic in_item_t header_word(logic [15:0] fc, logic [ADDR_W-1:0] a1,
			logic [ADDR_W-1:0] a2);
		in_item_t w;
		w.opcode              = OP_FRAME;
		w.frame_control       = fc;
		w.receiver_address    = a1;
		w.transmitter_address = a2;
		return w;
	endfunction

	function automatic in_item_t tick_word(logic [15:0] fc, logic [ADDR_W-1:0] a);
		in_item_t w;
		w.opcode              = OP_TICK;
		w.frame_control       = fc;
		w.receiver_address    = a;
		w.transmitter_address = a;
		return w;
	endfunction

	// Mostly well-formed to-DS data frames from the pool; some ticks, some
	// malformed headers, null or broadcast address 1 and our own address 2.
	function automatic in_item_t random_word();
		in_item_t w;
		int       kind;
		int       pick;
		kind = $urandom_range(99);
		w.opcode        = (kind < 14) ? OP_TICK : OP_FRAME;
		w.frame_control = 16'($urandom);
		if (kind >= 14 && kind < 88) begin
			w.frame_control[FC_TYPE_LSB +: 2] = FC_TYPE_DATA;
			w.frame_control[FC_TO_DS]         = 1'b1;
			w.frame_control[FC_FROM_DS]       = 1'b0;
		end
		pick = $urandom_range(99);
		if (pick < 4)
			w.receiver_address = '0;
		else if (pick < 8)
			w.receiver_address = '1;
		else
			w.receiver_address = random_mac();
		pick = $urandom_range(99);
		if (pick < 75)
			w.transmitter_address = stations[$urandom_range(POOL_SIZE - 1)];
		else if (pick < 85)
			w.transmitter_address = own_address;
		else
			w.transmitter_address = random_mac();
		return w;
	endfunction

	// Offer one word and hold it until the block takes it.
	task automatic send_word(in_item_t w);
		if (in_gaps) begin
			while ($urandom_range(99) < 16) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
	endtask

	// Drop valid and wait until every expected word is back, then a bit more.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write all three registers on consecutive edges; call only when idle.
	task automatic load_settings(logic [ADDR_W-1:0] local_addr, logic [5:0] max_clients,
			logic [15:0] flush_secs);
		cfg_we    <= 1'b1;
		cfg_index <= REG_LOCAL_ADDRESS;
		cfg_data  <= local_addr;
		@(posedge clk);
		cfg_index <= REG_MAX_TRACKED;
		cfg_data  <= ADDR_W'(max_clients);
		@(posedge clk);
		cfg_index <= REG_PURGE_INTERVAL;
		cfg_data  <= ADDR_W'(flush_secs);
		@(posedge clk);
		cfg_we      <= 1'b0;
		own_address  = local_addr;
		settings_run++;
	endtask

	initial begin
		int phase;
		int n;
		int waited;

		for (n = 0; n < POOL_SIZE; n++)
			stations[n] = random_mac();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset settings are local 0, limit 32, period 60.
		send_word(tick_word(16'h0000, '0));
		send_word(tick_word(16'hFFFF, '1));
		send_word(header_word(FC_QOS_DATA_TO_DS, AP_ADDR, STA_A));
		send_word(header_word(FC_QOS_DATA_TO_DS, AP_ADDR, STA_A));
		send_word(header_word(FC_DATA_TO_DS, '0, STA_B));
		send_word(header_word(FC_DATA_TO_DS, '1, STA_B));
		send_word(header_word(FC_DATA_TO_DS, AP_ADDR, '0));
		send_word(header_word(FC_DATA_BOTH_DS, AP_ADDR, STA_B));
		send_word(header_word(FC_DATA_NO_DS, AP_ADDR, STA_B));
		send_word(header_word(FC_MGMT_TO_DS, AP_ADDR, STA_B));
		send_word(header_word(16'hFFFF, AP_ADDR, STA_B));
		send_word(header_word(FC_DATA_TO_DS, AP_ADDR, STA_B));
		send_word(header_word(FC_DATA_TO_DS, AP_ADDR, '1));
		send_word(header_word(FC_QOS_DATA_TO_DS, '1 - 1, 48'd1));
		settle();

		// Count limit of four: the fifth client is flushed away at once.
		load_settings('0, 6'd4, 16'd60);
		send_word(header_word(FC_DATA_TO_DS, 48'd1, STA_C));
		send_word(header_word(FC_DATA_TO_DS, AP_ADDR, STA_C));
		settle();

		// Zero flush period: even a rejected frame clears the table.
		load_settings(STA_A, 6'd63, 16'd0);
		send_word(header_word(FC_QOS_DATA_TO_DS, AP_ADDR, STA_A));
		send_word(tick_word(FC_DATA_TO_DS, AP_ADDR));
		settle();

		// Time flush on a rejected frame after two ticks.
		load_settings('0, 6'd63, 16'd2);
		send_word(header_word(FC_DATA_TO_DS, AP_ADDR, STA_A));
		send_word(tick_word(16'h0000, '0));
		send_word(tick_word(16'h0000, '0));
		send_word(header_word(FC_DATA_TO_DS, '0, STA_B));
		send_word(header_word(FC_DATA_TO_DS, AP_ADDR, STA_B));
		settle();

		// Random phases, each under its own register setting.
		for (phase = 0; phase < PHASES; phase++) begin
			in_gaps  <= 1'b1;
			out_gaps <= 1'b1;
			case (phase)
				0: load_settings('0, 6'd63, 16'hFFFF);
				1: load_settings('1, 6'd0, 16'd1);
				2: begin
					// Run back to back with no idling on either side.
					in_gaps  <= 1'b0;
					out_gaps <= 1'b0;
					load_settings(stations[3], 6'd10, 16'd5);
				end
				3: load_settings(random_mac(), 6'd32, 16'd60);
				4: load_settings(stations[0], 6'd63, 16'd0);
				default: load_settings(stations[$urandom_range(POOL_SIZE - 1)],
					6'($urandom_range(63)), 16'($urandom_range(40, 1)));
			endcase
			// Hold off the receiver so the block backs up into its input.
			if (phase == 3 || phase == 6)
				hold_req <= ~hold_req;
			for (n = 0; n < WORDS_A_PHASE; n++)
				send_word(random_word());
			settle();
		end

		// Drain, then leave room for any stray word.
		in_valid <= 1'b0;
		waited    = 0;
		@(posedge clk);
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (80) @(posedge clk);

		$display("covered %0d words under %0d register settings", words_sent, settings_run);
		$display("predicted %0d client reports and %0d table flushes",
			reports_seen, flushes_seen);
		if (mismatches == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Stop a hung run.
	initial begin
		#20_000_000;
		$display("timeout with %0d words outstanding", pending);
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== wlan_client_station_tracker.f =====
+incdir+hw/rtl
hw/rtl/wcst_pkg.sv
hw/rtl/wcst_ram.sv
hw/rtl/wcst_ctrl.sv
hw/rtl/wcst_dp.sv
hw/rtl/wlan_client_station_tracker.sv
hw/rtl/wcst_checker.sv
dv/client_table_checker.sv
dv/testbench.sv
